>>> rtl/sng_pkg.sv
`default_nettype none

package sng_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOGM,
		ST_LOGA,
		ST_DBM,
		ST_DBA,
		ST_ENVM,
		ST_ENVA,
		ST_GATE,
		ST_DIVL,
		ST_DIVW,
		ST_EXPM1,
		ST_EXPA1,
		ST_EXPM2,
		ST_EXPA2,
		ST_WETM,
		ST_WETA,
		ST_DRYM,
		ST_DRYA,
		ST_MIXM,
		ST_MIXA,
		ST_DONE
	} sng_state_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIX       = 3'd5;

	localparam logic [14:0] THR_RESET     = 15'h5800;
	localparam logic [13:0] KNEE_RESET    = 14'd2560;
	localparam logic [14:0] RANGE_RESET   = 15'd15360;
	localparam logic [15:0] ATTACK_RESET  = 16'd65387;
	localparam logic [15:0] RELEASE_RESET = 16'd65521;
	localparam logic [16:0] MIX_RESET     = 17'h10000;
	localparam logic [16:0] MIX_UNITY     = 17'h10000;

	localparam int DB_FLOOR_MAG   = 30720;
	localparam int DB_PER_OCT_Q16 = 394566;
	localparam int OCT_PER_DB_Q16 = 10885;

	localparam int DIV_NUM_W = 38;
	localparam int DIV_DEN_W = 22;
	localparam int QUO_W     = 15;
	localparam int DIV_CNT_W = 4;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bt;
		int j;
		x = xin;
		r = '0;
		bt = 64'h4000_0000_0000_0000;
		for (j = 0; j < 32; j++) begin
			if (bt > x) bt = bt >> 2;
		end
		for (j = 0; j < 32; j++) begin
			if (bt != 64'd0) begin
				if (x >= r + bt) begin
					x = x - (r + bt);
					r = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
		end
		return r;
	endfunction

	// log2(1+i/n) in q16 by repeated squaring
	function automatic logic [16:0] log_entry(input int idx, input int bits);
		logic [63:0] m;
		logic [16:0] r;
		int b;
		m = ((64'(1 << bits) + 64'(idx)) << 30) >> bits;
		r = '0;
		if (m >= 64'h8000_0000) begin
			r = 17'h10000;
			m = m >> 1;
		end
		for (b = 15; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				r[b] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	// 2^(i/n) in q16 from products of square roots of two
	function automatic logic [17:0] exp_entry(input int idx, input int bits);
		logic [63:0] root [0:12];
		logic [63:0] p;
		int k;
		for (k = 0; k <= 12; k++) root[k] = '0;
		if (idx == (1 << bits)) return 18'd131072;
		root[0] = 64'h8000_0000;
		for (k = 1; k <= bits; k++) root[k] = isqrt64(root[k-1] << 30);
		p = 64'h4000_0000;
		for (k = 0; k < bits; k++) begin
			if (((idx >> k) & 1) != 0) p = (p * root[bits-k]) >> 30;
		end
		return 18'((p + 64'd8192) >> 14);
	endfunction

endpackage

`default_nettype wire

>>> rtl/sng_mul.sv
`default_nettype none

module sng_mul #(
	parameter int A_W = 25,
	parameter int B_W = 32
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

>>> rtl/sng_div.sv
`default_nettype none

module sng_div import sng_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= DIV_NUM_W'(req.den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

>>> rtl/stereo_noise_gate_soft_knee.sv
`default_nettype none

// Stereo noise gate with a soft knee. Each frame takes its peak magnitude to dB
// through a log2 curve table, runs a one-pole attack/release follower in dB,
// applies the soft-knee gate curve and turns the gain back to linear through an
// exp2 table before mixing wet and dry; all products go through one shared
// registered multiplier and the knee interpolation through a bit-serial divider.
// A frame steps through normalize (one shift per leading zero of the peak),
// log, dB, envelope, gate, the divider while the envelope is inside the knee
// (one quotient bit per cycle), exp and the wet/dry mix of each channel; a
// silent frame skips log and dB. in_stall is high after accept until the
// result is loaded into the output register, where it sits until taken while
// the next frame may already be accepted. Configuration is written through
// cfg_we, cfg_index and cfg_data, by the user only while no frame is in flight
// (the block does not enforce this); unknown indexes are ignored.
module stereo_noise_gate_soft_knee import sng_pkg::*; #(
	parameter int SAMPLE_BITS      = 24,
	parameter int CURVE_TABLE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int S    = SAMPLE_BITS;
	localparam int CTB  = CURVE_TABLE_BITS;
	localparam int N    = 1 << CTB;
	localparam int SH   = 16 - CTB;
	localparam int ZW   = $clog2(S);
	localparam int NO_W = ZW + 17;
	localparam int MA   = (S + 1 > 25) ? S + 1 : 25;
	localparam int MB   = 32;
	localparam int PW   = MA + MB;
	localparam int WW   = S + 1;

	localparam logic signed [PW-1:0] RND8  = PW'(128);
	localparam logic signed [PW-1:0] RND15 = PW'(32768);
	localparam logic signed [PW-1:0] RND23 = PW'(longint'(1) << 23);
	localparam logic signed [PW-1:0] RND29 = PW'(longint'(1) << 29);
	localparam logic signed [PW-1:0] OHI   = PW'((longint'(1) << (S - 1)) - 1);
	localparam logic signed [PW-1:0] OLO   = PW'(-(longint'(1) << (S - 1)));

	logic [16:0] log_rom [0:N];
	logic [17:0] exp_rom [0:N];

	for (genvar gi = 0; gi <= N; gi++) begin : g_rom
		localparam logic [16:0] LOG_V = log_entry(gi, CTB);
		localparam logic [17:0] EXP_V = exp_entry(gi, CTB);
		assign log_rom[gi] = LOG_V;
		assign exp_rom[gi] = EXP_V;
	end

	// configuration
	logic [14:0] threshold_q;
	logic [13:0] knee_q;
	logic [14:0] range_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [16:0] wet_mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
			knee_q      <= KNEE_RESET;
			range_q     <= RANGE_RESET;
			attack_q    <= ATTACK_RESET;
			release_q   <= RELEASE_RESET;
			wet_mix_q   <= MIX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[14:0];
				REG_KNEE:      knee_q      <= cfg_data[13:0];
				REG_RANGE:     range_q     <= cfg_data[14:0];
				REG_ATTACK:    attack_q    <= cfg_data[15:0];
				REG_RELEASE:   release_q   <= cfg_data[15:0];
				REG_MIX:       wet_mix_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	sng_state_t state_q, state_d;

	logic signed [S-1:0]    l_q, r_q;
	logic [S-1:0]           peak_q;
	logic [ZW-1:0]          z_q;
	logic [17:0]            base_q;
	logic [NO_W-1:0]        negoct_q;
	logic [14:0]            dbmag_q;
	logic signed [23:0]     env_q;
	logic [14:0]            gmag_q;
	logic [20:0]            m_q;
	logic [30:0]            g_q;
	logic signed [WW-1:0]   wet_q;
	logic signed [PW-1:0]   acc_q;
	logic                   chan_q;
	logic signed [S-1:0]    res_l_q, res_r_q;
	logic signed [S-1:0]    out_l_q, out_r_q;
	logic                   out_valid_q;

	logic signed [MA-1:0]   mul_a;
	logic signed [MB-1:0]   mul_b;
	logic signed [PW-1:0]   p_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                   in_acc;
	logic                   out_load;
	logic [S-1:0]           mag_l, mag_r, peak_in;
	logic [S+14:0]          frac_ext;
	logic [15:0]            frac;
	logic [CTB:0]           l_idx, l_idx1;
	logic [16:0]            l_diff;
	logic [SH-1:0]          l_rem;
	logic [16:0]            ex;
	logic [CTB:0]           e_idx, e_idx1;
	logic [17:0]            e_diff;
	logic [SH-1:0]          e_rem;
	logic [17:0]            ip_v;
	logic [NO_W-1:0]        negoct;
	logic signed [PW-1:0]   db_t;
	logic [14:0]            dbmag_n;
	logic signed [24:0]     in16, env25, env_diff;
	logic                   rising;
	logic [15:0]            coeff;
	logic signed [26:0]     env_sum;
	logic signed [23:0]     env_next;
	logic signed [22:0]     thr256;
	logic [20:0]            knee128;
	logic signed [25:0]     ks, ke, env26, ke_env;
	logic                   below, above;
	logic signed [PW-1:0]   m_t;
	logic [31:0]            g_full;
	logic signed [PW-1:0]   wet_t;
	logic signed [PW-1:0]   o_t;
	logic signed [S-1:0]    o_sat;
	logic [16:0]            mix_c, inv_mix;
	logic signed [S-1:0]    xc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	always_comb begin
		mag_l   = left_in[S-1] ? (~left_in + 1'b1) : left_in;
		mag_r   = right_in[S-1] ? (~right_in + 1'b1) : right_in;
		peak_in = (mag_l > mag_r) ? mag_l : mag_r;

		frac_ext = {peak_q[S-2:0], 16'h0000};
		frac     = frac_ext[S+14 -: 16];
		l_idx    = {1'b0, frac[15:SH]};
		l_idx1   = l_idx + 1'b1;
		l_diff   = log_rom[l_idx1] - log_rom[l_idx];
		l_rem    = frac[SH-1:0];

		ex     = 17'h10000 - {1'b0, m_q[15:0]};
		e_idx  = ex[16:SH];
		e_idx1 = ex[16] ? e_idx : e_idx + 1'b1;
		e_diff = exp_rom[e_idx1] - exp_rom[e_idx];
		e_rem  = ex[SH-1:0];

		ip_v    = base_q + 18'(p_q >>> SH);
		negoct  = NO_W'({z_q, 16'h0000}) - NO_W'(ip_v);
		db_t    = (p_q + RND23) >>> 24;
		dbmag_n = (db_t > PW'(DB_FLOOR_MAG)) ? 15'(DB_FLOOR_MAG) : db_t[14:0];

		in16     = -$signed({2'b00, dbmag_q, 8'h00});
		env25    = 25'(env_q);
		env_diff = env25 - in16;
		rising   = in16 > env25;
		coeff    = rising ? attack_q : release_q;
		env_sum  = 27'(in16) + 27'(p_q >>> 16);
		if (env_sum > 27'sd8388607) begin
			env_next = 24'sh7FFFFF;
		end else if (env_sum < -27'sd8388608) begin
			env_next = 24'sh800000;
		end else begin
			env_next = env_sum[23:0];
		end

		thr256  = $signed({threshold_q, 8'h00});
		knee128 = {knee_q, 7'b0};
		ks      = 26'(thr256) - $signed(26'(knee128));
		ke      = 26'(thr256) + $signed(26'(knee128));
		env26   = 26'(env_q);
		ke_env  = ke - env26;
		below   = env26 <= ks;
		above   = env26 >= ke;

		m_t    = (p_q + RND8) >>> 8;
		g_full = {ip_v, 14'h0000} >> ({1'b0, m_q[20:16]} + 6'd1);

		mix_c   = (wet_mix_q > MIX_UNITY) ? MIX_UNITY : wet_mix_q;
		inv_mix = MIX_UNITY - mix_c;
		xc      = chan_q ? r_q : l_q;
		wet_t   = (p_q + RND29) >>> 30;
		o_t     = (acc_q + p_q + RND15) >>> 16;
		if (o_t > OHI) begin
			o_sat = S'(OHI);
		end else if (o_t < OLO) begin
			o_sat = S'(OLO);
		end else begin
			o_sat = o_t[S-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = p_q[DIV_NUM_W-1:0] + DIV_NUM_W'(knee128);
		div_req.den   = {knee_q, 8'h00};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (peak_q == '0) begin
					state_d = ST_ENVM;
				end else if (peak_q[S-1]) begin
					state_d = ST_LOGM;
				end
			end
			ST_LOGM: begin
				mul_a   = MA'(l_diff);
				mul_b   = MB'(l_rem);
				state_d = ST_LOGA;
			end
			ST_LOGA: state_d = ST_DBM;
			ST_DBM: begin
				mul_a   = MA'(negoct_q);
				mul_b   = MB'(DB_PER_OCT_Q16);
				state_d = ST_DBA;
			end
			ST_DBA: state_d = ST_ENVM;
			ST_ENVM: begin
				mul_a   = MA'(env_diff);
				mul_b   = MB'(coeff);
				state_d = ST_ENVA;
			end
			ST_ENVA: state_d = ST_GATE;
			ST_GATE: begin
				mul_a   = MA'(ke_env[22:0]);
				mul_b   = MB'(range_q);
				state_d = (below || above) ? ST_EXPM1 : ST_DIVL;
			end
			ST_DIVL: begin
				div_req.start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (!div_rsp.busy) state_d = ST_EXPM1;
			end
			ST_EXPM1: begin
				mul_a   = MA'(gmag_q);
				mul_b   = MB'(OCT_PER_DB_Q16);
				state_d = ST_EXPA1;
			end
			ST_EXPA1: state_d = ST_EXPM2;
			ST_EXPM2: begin
				mul_a   = MA'(e_diff);
				mul_b   = MB'(e_rem);
				state_d = ST_EXPA2;
			end
			ST_EXPA2: state_d = ST_WETM;
			ST_WETM: begin
				mul_a   = MA'(xc);
				mul_b   = MB'(g_q);
				state_d = ST_WETA;
			end
			ST_WETA: state_d = ST_DRYM;
			ST_DRYM: begin
				mul_a   = MA'(xc);
				mul_b   = MB'(inv_mix);
				state_d = ST_DRYA;
			end
			ST_DRYA: state_d = ST_MIXM;
			ST_MIXM: begin
				mul_a   = MA'(wet_q);
				mul_b   = MB'(mix_c);
				state_d = ST_MIXA;
			end
			ST_MIXA: state_d = chan_q ? ST_DONE : ST_WETM;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	sng_mul #(
		.A_W(MA),
		.B_W(MB)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (p_q)
	);

	sng_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			chan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) chan_q <= 1'b0;
			if (state_q == ST_MIXA && !chan_q) chan_q <= 1'b1;
			if (state_q == ST_ENVA) env_q <= env_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					l_q    <= left_in;
					r_q    <= right_in;
					peak_q <= peak_in;
					z_q    <= '0;
				end
			end
			ST_NORM: begin
				if (peak_q == '0) begin
					dbmag_q <= 15'(DB_FLOOR_MAG);
				end else if (!peak_q[S-1]) begin
					peak_q <= peak_q << 1;
					z_q    <= z_q + 1'b1;
				end
			end
			ST_LOGM:  base_q   <= {1'b0, log_rom[l_idx]};
			ST_LOGA:  negoct_q <= negoct;
			ST_DBA:   dbmag_q  <= dbmag_n;
			ST_GATE: begin
				if (below) begin
					gmag_q <= range_q;
				end else if (above) begin
					gmag_q <= '0;
				end
			end
			ST_DIVW: begin
				if (!div_rsp.busy) gmag_q <= div_rsp.quo;
			end
			ST_EXPA1: m_q    <= m_t[20:0];
			ST_EXPM2: base_q <= exp_rom[e_idx];
			ST_EXPA2: g_q    <= g_full[30:0];
			ST_WETA:  wet_q  <= WW'(wet_t);
			ST_DRYA:  acc_q  <= p_q;
			ST_MIXA: begin
				if (chan_q) begin
					res_r_q <= o_sat;
				end else begin
					res_l_q <= o_sat;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_l_q <= res_l_q;
					out_r_q <= res_r_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_env_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !in_acc) |=> $stable(env_q))
		else $error("envelope moved while idle");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPM1) |-> (gmag_q <= range_q))
		else $error("gate attenuation beyond range");

	a_db_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENVM) |-> (dbmag_q <= 15'(DB_FLOOR_MAG)))
		else $error("level below floor");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("item presented outside done");
`endif

endmodule

`default_nettype wire

>>> tb/stereo_noise_gate_soft_knee_test.sv
`default_nettype none

module stereo_noise_gate_soft_knee_test;
	import sng_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 24;
	localparam int TB = 8;
	localparam int TN = 1 << TB;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 80;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [SW-1:0] left;
		logic [SW-1:0] right;
	} frame_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [SW-1:0] left_in;
	logic signed [SW-1:0] right_in;
	logic out_valid;
	logic out_stall;
	logic signed [SW-1:0] left_out;
	logic signed [SW-1:0] right_out;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stereo_noise_gate_soft_knee #(.SAMPLE_BITS(SW), .CURVE_TABLE_BITS(TB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_out(left_out), .right_out(right_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [63:0] log_curve [0:TN];
	logic [63:0] exp_curve [0:TN];
	logic [14:0] m_thr;
	logic [13:0] m_knee;
	logic [14:0] m_range;
	logic [15:0] m_attack;
	logic [15:0] m_release;
	logic [16:0] m_mix;
	longint m_env;

	frame_t pend_q[$];
	frame_t gated_q[$];
	int errors;
	int cyc;
	int hold_start;
	bit idle_on;
	int gap_left;
	int stall_left;
	logic rx_hold;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] xin);
		logic [63:0] x, r, bt;
		x = xin;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	task automatic fill_curves();
		logic [63:0] root [0:TB];
		logic [63:0] m, r, p;
		for (int i = 0; i <= TN; i++) begin
			m = (64'(TN + i) << 30) >> TB;
			r = 0;
			if (m >= (64'd1 << 31)) begin
				r = 65536;
				m = m >> 1;
			end
			for (int b = 15; b >= 0; b--) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					r = r | (64'd1 << b);
					m = m >> 1;
				end
			end
			log_curve[i] = r;
		end
		root[0] = 64'd1 << 31;
		for (int k = 1; k <= TB; k++) root[k] = int_sqrt(root[k-1] << 30);
		for (int i = 0; i < TN; i++) begin
			p = 64'd1 << 30;
			for (int k = 0; k < TB; k++)
				if ((i >> k) & 1) p = (p * root[TB-k]) >> 30;
			exp_curve[i] = (p + 64'd8192) >> 14;
		end
		exp_curve[TN] = 131072;
	endtask

	function automatic logic [63:0] curve_at(input bit use_exp, input logic [63:0] x);
		logic [63:0] idx, rem, a, b;
		idx = x >> (16 - TB);
		rem = x & ((64'd1 << (16 - TB)) - 1);
		if (idx >= TN) return use_exp ? exp_curve[TN] : log_curve[TN];
		a = use_exp ? exp_curve[idx] : log_curve[idx];
		b = use_exp ? exp_curve[idx+1] : log_curve[idx+1];
		return a + (((b - a) * rem) >> (16 - TB));
	endfunction

	function automatic logic [SW-1:0] mix_channel(input longint x, input longint g,
			input longint mix);
		longint wet, o;
		wet = (x * g + (64'sd1 <<< 29)) >>> 30;
		o = (x * (65536 - mix) + wet * mix + 32768) >>> 16;
		if (o > 8388607) o = 8388607;
		if (o < -8388608) o = -8388608;
		return o[SW-1:0];
	endfunction

	task automatic gain_frame_predict(input frame_t f, output frame_t res);
		longint l, r, db, oct, in16, nxt, thr, ks, ke, gdb, mix;
		logic [63:0] pk, fr, coeff, a, m, oi, v, g, sh;
		int e;
		l = longint'($signed(f.left));
		r = longint'($signed(f.right));
		pk = (l < 0 ? -l : l) > (r < 0 ? -r : r) ? (l < 0 ? -l : l) : (r < 0 ? -r : r);
		db = -30720;
		if (pk != 0) begin
			e = 0;
			while ((pk >> (e + 1)) != 0) e++;
			fr = ((pk - (64'd1 << e)) << 16) >> e;
			oct = longint'(e - (SW - 1)) * 65536 + longint'(curve_at(0, fr));
			db = -longint'((64'(-oct) * 394566 + (64'd1 << 23)) >> 24);
			if (db < -30720) db = -30720;
		end
		in16 = db * 256;
		coeff = in16 > m_env ? m_attack : m_release;
		nxt = in16 + (((m_env - in16) * longint'(coeff)) >>> 16);
		if (nxt > 8388607) nxt = 8388607;
		if (nxt < -8388608) nxt = -8388608;
		m_env = nxt;
		thr = longint'($signed(m_thr));
		ks = thr * 256 - longint'(m_knee) * 128;
		ke = thr * 256 + longint'(m_knee) * 128;
		if (nxt <= ks) gdb = -longint'(m_range);
		else if (nxt >= ke) gdb = 0;
		else gdb = -longint'((64'(m_range) * 64'(ke - nxt) + 64'(m_knee) * 128)
			/ (64'(m_knee) * 256));
		a = 64'(-gdb);
		m = (a * 10885 + 128) >> 8;
		oi = m >> 16;
		v = curve_at(1, 65536 - (m & 64'hFFFF));
		sh = oi >= 62 ? 63 : oi + 1;
		g = (v << 14) >> sh;
		mix = m_mix > 65536 ? 65536 : longint'(m_mix);
		res.left = mix_channel(l, longint'(g), mix);
		res.right = mix_channel(r, longint'(g), mix);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		case (idx)
			REG_THRESHOLD: m_thr = 15'(val);
			REG_KNEE: m_knee = 14'(val);
			REG_RANGE: m_range = 15'(val);
			REG_ATTACK: m_attack = 16'(val);
			REG_RELEASE: m_release = 16'(val);
			REG_MIX: m_mix = 17'(val);
			default: ;
		endcase
	endtask

	task automatic set_gate(input int thr, input int knee, input int rng, input int att,
			input int rel, input int mix);
		reg_write(REG_THRESHOLD, thr);
		reg_write(REG_KNEE, knee);
		reg_write(REG_RANGE, rng);
		reg_write(REG_ATTACK, att);
		reg_write(REG_RELEASE, rel);
		reg_write(REG_MIX, mix);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || in_valid || gated_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [SW-1:0] level_sample(input int shift);
		logic [31:0] v;
		v = $urandom() >> (8 + shift);
		if ($urandom_range(0, 1)) v = -v;
		return v[SW-1:0];
	endfunction

	task automatic push_frame(input logic [SW-1:0] a, input logic [SW-1:0] b);
		frame_t f;
		f.left = a;
		f.right = b;
		pend_q.push_back(f);
	endtask

	task automatic push_random(input int n);
		int shift, run, k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 4) == 0) begin
				push_frame(SW'($urandom()), SW'($urandom()));
				k++;
			end else begin
				shift = $urandom_range(0, 23);
				run = $urandom_range(8, 40);
				for (int j = 0; j < run && k < n; j++) begin
					if ($urandom_range(0, 9) == 0) push_frame('0, '0);
					else push_frame(level_sample(shift), level_sample(shift + $urandom_range(0, 3)));
					k++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		rx_hold <= (cyc >= hold_start) && (cyc < hold_start + 600);
		if (cyc > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin : drive
		frame_t nf, res;
		bit take;
		int rr;
		if (arst_n) begin
			take = 1'b0;
			if (in_valid && !in_stall) begin
				nf.left = left_in;
				nf.right = right_in;
				gain_frame_predict(nf, res);
				gated_q.push_back(res);
				if (idle_on) begin
					rr = $urandom_range(0, 99);
					gap_left = rr < 70 ? 0 : (rr < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60));
				end
				take = 1'b1;
			end
			if (!in_valid || take) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					nf = pend_q.pop_front();
					left_in <= nf.left;
					right_in <= nf.right;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		frame_t want;
		bit s;
		int rr;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (gated_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected item: %h %h", left_out, right_out);
				end else begin
					want = gated_q.pop_front();
					if (want.left !== left_out || want.right !== right_out) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: want %h %h got %h %h",
								want.left, want.right, left_out, right_out);
					end
				end
			end
			s = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				s = 1'b1;
			end else if (idle_on) begin
				rr = $urandom_range(0, 99);
				if (rr < 20) begin
					stall_left = rr < 2 ? $urandom_range(20, 80) : $urandom_range(0, 3);
					s = 1'b1;
				end
			end
			out_stall <= s || rx_hold;
		end
	end

	initial begin
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cyc = 0;
		hold_start = 32'h7FFF_FFFF;
		idle_on = 1'b0;
		gap_left = 0;
		stall_left = 0;
		rx_hold = 1'b0;
		m_thr = THR_RESET;
		m_knee = KNEE_RESET;
		m_range = RANGE_RESET;
		m_attack = ATTACK_RESET;
		m_release = RELEASE_RESET;
		m_mix = MIX_RESET;
		m_env = 0;
		fill_curves();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, no idling
		push_frame(24'h7FFFFF, 24'h7FFFFF);
		push_frame(24'h800000, 24'h000000);
		push_frame(24'h000000, 24'h800000);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h000001, 24'hFFFFFF);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h400000, 24'hC00000);
		push_frame(24'h000010, 24'h000020);
		push_frame(24'h7FFFFF, 24'h800000);
		push_frame(24'h00FFFF, 24'hFF0001);
		push_frame(24'h555555, 24'hAAAAAA);
		wait_drained();

		// hard gate, deepest range, instant follower, dry only
		set_gate(0, 0, 32767, 0, 0, 0);
		push_frame(24'h7FFFFF, 24'h000001);
		push_frame(24'h000100, 24'hFFFF00);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h800000, 24'h7FFFFF);
		wait_drained();
		reg_write(REG_MIX, 131071);
		reg_write(REG_SPARE_LO, 1);
		reg_write(REG_SPARE_HI, 65536);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_frame(24'h000001, 24'h000000);
		push_frame(24'h7FFFFF, 24'h123456);
		push_frame(24'h000000, 24'hFEDCBA);
		wait_drained();

		idle_on = 1'b1;
		set_gate(-10240, 2560, 15360, 65387, 65521, 65536);
		push_random(240);
		wait_drained();

		// receiver holds off while frames keep coming
		hold_start = cyc + 20;
		set_gate(-15360, 10240, 25600, 65535, 65535, 65536);
		push_random(240);
		wait_drained();

		set_gate(16383, 16383, 25600, 32768, 1000, 32768);
		push_random(240);
		wait_drained();

		set_gate(-8192, 6000, 12000, 0, 65535, 40000);
		push_random(240);
		wait_drained();

		idle_on = 1'b0;
		set_gate(-5000, 1, 20000, 60000, 62000, 65536);
		push_random(240);
		wait_drained();

		idle_on = 1'b1;
		set_gate(-16384, 8000, 0, 50000, 64000, 131071);
		push_random(240);
		wait_drained();

		set_gate(-12000, 3000, 18000, 65000, 65500, 65536);
		push_random(240);
		wait_drained();

		set_gate(-2560, 0, 25600, 20000, 65000, 70000);
		push_random(240);
		wait_drained();

		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire
